### hw/rtl/ordered_list_append_delete_key_defines.svh
// Assertion macros used by the checker file.
`ifndef ORDERED_LIST_APPEND_DELETE_KEY_DEFINES_SVH
`define ORDERED_LIST_APPEND_DELETE_KEY_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define OLAD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("olad check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define OLAD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("olad check failed");

`endif

### hw/rtl/olad_pkg.sv
package olad_pkg;

    localparam int CMD_W = 2;
    localparam int VAL_W = 32;
    localparam int POS_W = 4;
    localparam int ST_W  = 2;
    localparam int LEN_W = 5;

    localparam int CAPACITY_DEF = 16;

    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [ST_W-1:0] ST_RANGE     = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_FIN
    } state_t;

    typedef struct packed {
        logic        [CMD_W-1:0] command;
        logic signed [VAL_W-1:0] value;
        logic        [POS_W-1:0] position;
    } item_t;

    typedef struct packed {
        logic        [ST_W-1:0]  status;
        logic signed [VAL_W-1:0] read_value;
        logic        [LEN_W-1:0] length;
    } result_t;

endpackage

### hw/rtl/olad_ram.sv
module olad_ram #(
    parameter int DEPTH = olad_pkg::CAPACITY_DEF,
    parameter int AW    = $clog2(DEPTH),
    parameter int DW    = olad_pkg::VAL_W
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // hold the last read word until the next read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hw/rtl/ordered_list_append_delete_key.sv
// Ordered list of up to CAPACITY signed 32-bit values held in one on-chip
// RAM (one write port, one read port, registered read), head at
// entry 0. Each command beat appends a value at the tail, deletes the first
// entry equal to a key (later entries move up one slot, order kept) or reads
// the entry at a position; every command gives exactly one response beat
// with status, read value (zero unless a read succeeds) and the length after
// the command. Commands are handled one at a time: cmd_ready is high only
// while no command is in flight, and the response register lets the next
// command in while the previous response still waits. Append, read and the
// unused code go from accept straight to the finish state. A delete
// scans and may close up: the scan reads one entry per cycle from the head
// up to the match, and the close-up copies one entry per cycle from the
// match to the tail, both paced by the single RAM read port. No clearing
// pass is needed after reset: only entries below the count are ever read.
module ordered_list_append_delete_key #(
    parameter int CAPACITY = olad_pkg::CAPACITY_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  olad_pkg::item_t  cmd,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output olad_pkg::result_t rsp
);

    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > olad_pkg::POS_W) ? CW : olad_pkg::POS_W;

    olad_pkg::state_t state_reg, state_next;

    logic [AW-1:0]                  idx_reg, idx_next;
    logic [CW-1:0]                  count_reg, count_next;
    logic [olad_pkg::CMD_W-1:0]     cmd_reg, cmd_next;
    logic [olad_pkg::VAL_W-1:0]     key_reg, key_next;
    logic [olad_pkg::ST_W-1:0]      status_reg, status_next;
    logic                           rsp_valid_reg, rsp_valid_next;
    olad_pkg::result_t              rsp_reg, rsp_next;

    logic                           wr_en;
    logic [AW-1:0]                  wr_addr;
    logic [olad_pkg::VAL_W-1:0]     wr_data;
    logic                           rd_en;
    logic [AW-1:0]                  rd_addr;
    logic [olad_pkg::VAL_W-1:0]     rd_data;

    logic                           accept;
    logic                           has_room;
    logic                           is_empty;
    logic                           pos_ok;
    logic                           hit;
    logic [CW-1:0]                  idx_plus1;
    logic [CW-1:0]                  idx_plus2;
    logic                           more_scan;
    logic                           more_shift;
    logic                           slot_free;

    olad_ram #(
        .DEPTH (CAPACITY),
        .AW    (AW),
        .DW    (olad_pkg::VAL_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign cmd_ready = (state_reg == olad_pkg::S_IDLE);
    assign accept    = cmd_valid && cmd_ready;

    assign has_room  = (count_reg < CW'(CAPACITY));
    assign is_empty  = (count_reg == '0);
    assign pos_ok    = (CMPW'(cmd.position) < CMPW'(count_reg));

    // rd_data is the entry at idx_reg during the scan, and at idx_reg + 1
    // during the close-up; reads always run ahead of the write slot, so a
    // read never targets the entry being written in the same cycle.
    assign hit        = (rd_data == key_reg);
    assign idx_plus1  = CW'(idx_reg) + CW'(1);
    assign idx_plus2  = CW'(idx_reg) + CW'(2);
    assign more_scan  = (idx_plus1 < count_reg);
    assign more_shift = (idx_plus2 < count_reg);

    // the response register can take a new beat this cycle
    assign slot_free  = !rsp_valid_reg || rsp_ready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            olad_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if ((cmd.command == olad_pkg::CMD_DELETE) && !is_empty)
                    begin
                        state_next = olad_pkg::S_SCAN;
                    end
                    else
                    begin
                        state_next = olad_pkg::S_FIN;
                    end
                end
            end
            olad_pkg::S_SCAN:
            begin
                if (hit && more_scan)
                begin
                    state_next = olad_pkg::S_SHIFT;
                end
                else if (hit || !more_scan)
                begin
                    state_next = olad_pkg::S_FIN;
                end
            end
            olad_pkg::S_SHIFT:
            begin
                if (!more_shift)
                begin
                    state_next = olad_pkg::S_FIN;
                end
            end
            olad_pkg::S_FIN:
            begin
                if (slot_free)
                begin
                    state_next = olad_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = olad_pkg::S_IDLE;
            end
        endcase
    end

    // datapath and RAM control
    always_comb
    begin
        idx_next       = idx_reg;
        count_next     = count_reg;
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        status_next    = status_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        wr_en          = 1'b0;
        wr_addr        = idx_reg;
        wr_data        = rd_data;
        rd_en          = 1'b0;
        rd_addr        = '0;
        case (state_reg)
            olad_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next    = cmd.command;
                    key_next    = cmd.value;
                    idx_next    = '0;
                    status_next = olad_pkg::ST_OK;
                    case (cmd.command)
                        olad_pkg::CMD_APPEND:
                        begin
                            if (has_room)
                            begin
                                // write the tail slot, grow the list
                                wr_en      = 1'b1;
                                wr_addr    = AW'(count_reg);
                                wr_data    = cmd.value;
                                count_next = count_reg + CW'(1);
                            end
                            else
                            begin
                                status_next = olad_pkg::ST_FULL;
                            end
                        end
                        olad_pkg::CMD_DELETE:
                        begin
                            if (is_empty)
                            begin
                                status_next = olad_pkg::ST_NOT_FOUND;
                            end
                            else
                            begin
                                rd_en   = 1'b1;
                                rd_addr = '0;
                            end
                        end
                        olad_pkg::CMD_READ:
                        begin
                            if (pos_ok)
                            begin
                                rd_en   = 1'b1;
                                rd_addr = AW'(cmd.position);
                            end
                            else
                            begin
                                status_next = olad_pkg::ST_RANGE;
                            end
                        end
                        default:
                        begin
                            status_next = olad_pkg::ST_OK;
                        end
                    endcase
                end
            end
            olad_pkg::S_SCAN:
            begin
                if (hit)
                begin
                    if (more_scan)
                    begin
                        // fetch the entry after the match; idx stays as write slot
                        rd_en   = 1'b1;
                        rd_addr = AW'(idx_plus1);
                    end
                    else
                    begin
                        // match at the tail: just drop it
                        count_next = count_reg - CW'(1);
                    end
                end
                else if (more_scan)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = AW'(idx_plus1);
                    idx_next = AW'(idx_plus1);
                end
                else
                begin
                    status_next = olad_pkg::ST_NOT_FOUND;
                end
            end
            olad_pkg::S_SHIFT:
            begin
                // move the fetched entry up one slot
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                wr_data = rd_data;
                if (more_shift)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = AW'(idx_plus2);
                    idx_next = AW'(idx_plus1);
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            olad_pkg::S_FIN:
            begin
                if (slot_free)
                begin
                    rsp_valid_next     = 1'b1;
                    rsp_next.status    = status_reg;
                    rsp_next.length    = olad_pkg::LEN_W'(count_reg);
                    rsp_next.read_value = '0;
                    if ((cmd_reg == olad_pkg::CMD_READ) && (status_reg == olad_pkg::ST_OK))
                    begin
                        rsp_next.read_value = rd_data;
                    end
                end
            end
            default:
            begin
                rsp_valid_next = rsp_valid_reg && !rsp_ready;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= olad_pkg::S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        cmd_reg    <= cmd_next;
        key_reg    <= key_next;
        status_reg <= status_next;
        rsp_reg    <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### hw/rtl/olad_checker.sv
`include "ordered_list_append_delete_key_defines.svh"

module olad_checker #(
    parameter int CAPACITY = olad_pkg::CAPACITY_DEF
) (
    input logic              clk,
    input logic              rst_n,
    input logic              cmd_valid,
    input logic              cmd_ready,
    input olad_pkg::item_t   cmd,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input olad_pkg::result_t rsp
);

    // a stalled response beat holds
    `OLAD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

    // one command at a time: no accept right after an accept
    `OLAD_ASSERT_NEXT(a_one_in_flight, cmd_valid && cmd_ready, !cmd_ready)

    // only a successful read carries a nonzero value
    `OLAD_ASSERT_NOW(a_value_zero, rsp_valid && (rsp.status != olad_pkg::ST_OK), rsp.read_value == '0)

    // full is reported only at capacity
    `OLAD_ASSERT_NOW(a_full_len, rsp_valid && (rsp.status == olad_pkg::ST_FULL), rsp.length == olad_pkg::LEN_W'(CAPACITY))

    // length never exceeds capacity while it fits the field
    `OLAD_ASSERT_NOW(a_len_max, rsp_valid && (CAPACITY < 32), 32'(rsp.length) <= 32'(CAPACITY))

endmodule

bind ordered_list_append_delete_key olad_checker #(
    .CAPACITY (CAPACITY)
) u_olad_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
